[hdl/priority_ready_list_unit_defines.svh]
// ----------------------------------------------------------------------------
// Priority ready list assertion macros
// Shared assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_LIST_UNIT_DEFINES_SVH
`define PRIORITY_READY_LIST_UNIT_DEFINES_SVH

// implication checked on every edge outside reset
`define PRL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/prl_pkg.sv]
// ----------------------------------------------------------------------------
// Priority ready list package
// Widths, command and status codes, and the request record.
// ----------------------------------------------------------------------------
`default_nettype none
package prl_pkg;
	localparam int MAX_JOBS_DEF    = 32;
	localparam int PRIO_LEVELS_DEF = 32;
	localparam int CMD_W = 2;
	localparam int ID_W  = 5;
	localparam int PR_W  = 5;
	localparam int ST_W  = 2;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_DUP   = 2'd2;
	localparam logic [ST_W-1:0] ST_NOTQ  = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [ID_W-1:0]  job_id;
		logic [PR_W-1:0]  prio;
		logic             in_range;
	} prl_req_t;
endpackage
`default_nettype wire

[hdl/prl_front.sv]
// ----------------------------------------------------------------------------
// Priority ready list front end
// Accept requests, saturate priority, flag slot range, queue two deep.
// ----------------------------------------------------------------------------
`default_nettype none
module prl_front import prl_pkg::*; #(
	parameter int MAX_JOBS    = MAX_JOBS_DEF,
	parameter int PRIO_LEVELS = PRIO_LEVELS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [CMD_W-1:0] command,
	input  wire logic [ID_W-1:0]  job_id,
	input  wire logic [PR_W-1:0]  priority_req,
	output logic                  req_valid,
	output prl_req_t              req,
	input  wire logic             req_take
);
	prl_req_t   fifo_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	prl_req_t   in_req;
	logic       do_wr, do_rd;

	always_comb begin
		in_req.command  = command;
		in_req.job_id   = job_id;
		in_req.in_range = (32'(job_id) < MAX_JOBS);
		if (32'(priority_req) >= PRIO_LEVELS) begin
			in_req.prio = PR_W'(PRIO_LEVELS - 1);
		end else begin
			in_req.prio = priority_req;
		end
	end

	assign full      = (cnt_q == 2'd2);
	assign req_valid = (cnt_q != 2'd0);
	assign req       = fifo_q[rd_q];
	assign do_wr     = push && !full;
	assign do_rd     = req_take && req_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			fifo_q[wr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) wr_q <= !wr_q;
			if (do_rd) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
		end
	end
endmodule
`default_nettype wire

[hdl/prl_back.sv]
// ----------------------------------------------------------------------------
// Priority ready list back end
// Walk and relink the list in link memories.
// ----------------------------------------------------------------------------
`default_nettype none
module prl_back import prl_pkg::*; #(
	parameter int MAX_JOBS    = MAX_JOBS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	input  wire prl_req_t        req,
	output logic                 req_take,
	output logic                 empty,
	input  wire logic            pop,
	output logic [ID_W-1:0]      result_job,
	output logic [ST_W-1:0]      status,
	output logic                 head_valid,
	output logic [ID_W-1:0]      head_job
);
	localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int LW = $clog2(MAX_JOBS + 1);
	localparam int CW = $clog2(MAX_JOBS + 1);
	localparam logic [LW-1:0] NONE = LW'(MAX_JOBS);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_WRD   = 4'd1;
	localparam logic [3:0] S_WCHK  = 4'd2;
	localparam logic [3:0] S_LNK1  = 4'd3;
	localparam logic [3:0] S_LNK2  = 4'd4;
	localparam logic [3:0] S_LNK3  = 4'd5;
	localparam logic [3:0] S_URD   = 4'd6;
	localparam logic [3:0] S_UWAIT = 4'd7;
	localparam logic [3:0] S_ULNK1 = 4'd8;
	localparam logic [3:0] S_ULNK2 = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	logic [LW-1:0]   next_mem [MAX_JOBS];
	logic [LW-1:0]   prev_mem [MAX_JOBS];
	logic [PR_W-1:0] prio_mem [MAX_JOBS];
	logic [MAX_JOBS-1:0] queued_q;

	logic [3:0]      state_q;
	logic [LW-1:0]   head_q;
	prl_req_t        cur_q;
	logic [IW-1:0]   tgt_q;
	logic [LW-1:0]   ref_q, last_q;
	logic [CW-1:0]   steps_q;
	logic [LW-1:0]   rd_next_q, rd_prev_q;
	logic [PR_W-1:0] rd_prio_q;
	logic [IW-1:0]   rd_addr;
	logic            out_full_q;
	logic [ID_W-1:0] res_q;
	logic [ST_W-1:0] st_q;
	logic            id_queued;

	assign req_take   = (state_q == S_IDLE) && !out_full_q;
	assign empty      = !out_full_q;
	assign result_job = res_q;
	assign status     = st_q;
	assign head_valid = (head_q != NONE);
	assign head_job   = head_valid ? ID_W'(head_q) : '0;
	assign id_queued  = req.in_range && queued_q[IW'(req.job_id)];

	always_comb begin
		rd_addr = tgt_q;
		if (state_q == S_WRD) rd_addr = IW'(ref_q);
	end

	always_ff @(posedge clk) begin
		rd_next_q <= next_mem[rd_addr];
		rd_prev_q <= prev_mem[rd_addr];
		rd_prio_q <= prio_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_LNK1: begin
				prio_mem[tgt_q] <= cur_q.prio;
				prev_mem[tgt_q] <= last_q;
				next_mem[tgt_q] <= ref_q;
			end
			S_LNK2: if (ref_q != NONE) prev_mem[IW'(ref_q)] <= LW'(tgt_q);
			S_LNK3: if (last_q != NONE) next_mem[IW'(last_q)] <= LW'(tgt_q);
			S_ULNK1: if (rd_next_q != NONE) prev_mem[IW'(rd_next_q)] <= rd_prev_q;
			S_ULNK2: if (rd_prev_q != NONE) next_mem[IW'(rd_prev_q)] <= rd_next_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= NONE;
			queued_q   <= '0;
			out_full_q <= 1'b0;
			cur_q      <= '0;
			tgt_q      <= '0;
			ref_q      <= NONE;
			last_q     <= NONE;
			steps_q    <= '0;
			res_q      <= '0;
			st_q       <= ST_OK;
		end else begin
			if (pop && out_full_q) out_full_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (req_valid && !out_full_q) begin
					cur_q <= req;
					unique case (req.command)
						CMD_INSERT: begin
							tgt_q <= IW'(req.job_id);
							res_q <= req.job_id;
							if (!req.in_range) begin
								st_q    <= ST_NOTQ;
								state_q <= S_DONE;
							end else if (id_queued) begin
								st_q    <= ST_DUP;
								state_q <= S_DONE;
							end else begin
								st_q    <= ST_OK;
								ref_q   <= head_q;
								last_q  <= NONE;
								steps_q <= '0;
								state_q <= S_WRD;
							end
						end
						CMD_REMOVE: begin
							tgt_q <= IW'(req.job_id);
							res_q <= req.job_id;
							if (!id_queued) begin
								st_q    <= ST_NOTQ;
								state_q <= S_DONE;
							end else begin
								st_q    <= ST_OK;
								state_q <= S_URD;
							end
						end
						CMD_POP: begin
							if (head_q == NONE) begin
								res_q   <= '0;
								st_q    <= ST_EMPTY;
								state_q <= S_DONE;
							end else begin
								res_q   <= ID_W'(head_q);
								st_q    <= ST_OK;
								tgt_q   <= IW'(head_q);
								state_q <= S_URD;
							end
						end
						default: begin
							res_q   <= '0;
							st_q    <= ST_OK;
							state_q <= S_DONE;
						end
					endcase
				end
				S_WRD: begin
					if (ref_q == NONE || 32'(steps_q) >= MAX_JOBS) begin
						ref_q   <= NONE;
						state_q <= S_LNK1;
					end else begin
						state_q <= S_WCHK;
					end
				end
				S_WCHK: begin
					if (rd_prio_q <= cur_q.prio) begin
						last_q  <= ref_q;
						ref_q   <= rd_next_q;
						steps_q <= steps_q + 1'b1;
						state_q <= S_WRD;
					end else begin
						state_q <= S_LNK1;
					end
				end
				S_LNK1: state_q <= S_LNK2;
				S_LNK2: state_q <= S_LNK3;
				S_LNK3: begin
					if (last_q == NONE) head_q <= LW'(tgt_q);
					queued_q[tgt_q] <= 1'b1;
					state_q <= S_DONE;
				end
				S_URD:   state_q <= S_UWAIT;
				S_UWAIT: state_q <= S_ULNK1;
				S_ULNK1: state_q <= S_ULNK2;
				S_ULNK2: begin
					if (rd_prev_q == NONE) head_q <= rd_next_q;
					queued_q[tgt_q] <= 1'b0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					out_full_q <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[hdl/priority_ready_list_unit.sv]
// ----------------------------------------------------------------------------
// Priority ready list unit
// Priority-ordered ready queue of job slots with insert, remove and pop.
// ----------------------------------------------------------------------------
//  channel  | handshake          | fields
//  request  | push / full        | command, job_id, priority_req
//  result   | pop / empty        | result_job, status, head_valid, head_job
//
//  Insert walks the list from the head past every job of equal or lower
//  priority (up to MAX_JOBS links) and links the new job in before the first
//  job of larger priority or at the tail; remove and pop unlink one job.
//  Reset empties the list at once; no clearing pass.
//  A two-deep request queue keeps accepting while the back end works, until full.
//  The back end stalls while a result waits to be popped.
`default_nettype none
module priority_ready_list_unit import prl_pkg::*; #(
	parameter int MAX_JOBS    = MAX_JOBS_DEF,
	parameter int PRIO_LEVELS = PRIO_LEVELS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [CMD_W-1:0] command,
	input  wire logic [ID_W-1:0]  job_id,
	input  wire logic [PR_W-1:0]  priority_req,
	output logic                  empty,
	input  wire logic             pop,
	output logic [ID_W-1:0]       result_job,
	output logic [ST_W-1:0]       status,
	output logic                  head_valid,
	output logic [ID_W-1:0]       head_job
);
	logic     req_valid, req_take;
	prl_req_t req;

	prl_front #(.MAX_JOBS(MAX_JOBS), .PRIO_LEVELS(PRIO_LEVELS)) u_front (
		.clk, .arst_n, .push, .full, .command, .job_id, .priority_req,
		.req_valid, .req, .req_take
	);

	prl_back #(.MAX_JOBS(MAX_JOBS)) u_back (
		.clk, .arst_n, .req_valid, .req, .req_take, .empty, .pop,
		.result_job, .status, .head_valid, .head_job
	);
endmodule
`default_nettype wire

[hdl/prl_checker.sv]
// ----------------------------------------------------------------------------
// Priority ready list checker
// Port-level properties of the ready queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "priority_ready_list_unit_defines.svh"
module prl_checker import prl_pkg::*; (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            empty,
	input wire logic            pop,
	input wire logic [ID_W-1:0] result_job,
	input wire logic [ST_W-1:0] status,
	input wire logic            head_valid,
	input wire logic [ID_W-1:0] head_job
);
	`PRL_ASSERT_IMPL(a_head_zero, clk, arst_n, !head_valid, head_job == '0, "head_job not zero")
	`PRL_ASSERT_IMPL(a_empty_pop, clk, arst_n, !empty && status == ST_EMPTY, !head_valid && result_job == '0, "empty status with head")
	`PRL_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(result_job) && $stable(status), "result changed while held")
	`PRL_ASSERT_IMPL(a_dup_head, clk, arst_n, !empty && status == ST_DUP, head_valid, "duplicate with empty list")
endmodule

bind priority_ready_list_unit prl_checker u_prl_checker (
	.clk, .arst_n, .empty, .pop, .result_job, .status, .head_valid, .head_job
);
`default_nettype wire

[verif/priority_ready_list_unit_checker.sv]
// ----------------------------------------------------------------------------
// Priority ready list checker
// Watches the request and result channels, keeps its own ordered job list,
// predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module priority_ready_list_unit_checker import prl_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic             full,
	input  wire logic [CMD_W-1:0] command,
	input  wire logic [ID_W-1:0]  job_id,
	input  wire logic [PR_W-1:0]  priority_req,
	input  wire logic             empty,
	input  wire logic             pop,
	input  wire logic [ID_W-1:0]  result_job,
	input  wire logic [ST_W-1:0]  status,
	input  wire logic             head_valid,
	input  wire logic [ID_W-1:0]  head_job,
	output int                    errors,
	output int                    pending
);
	typedef struct packed {
		logic [ID_W-1:0] job;
		logic [ST_W-1:0] st;
		logic            hv;
		logic [ID_W-1:0] hj;
	} prl_result_t;

	prl_result_t expected_results[$];
	int ready_order[$];
	logic [PR_W-1:0] prio_of[MAX_JOBS_DEF];

	assign pending = expected_results.size();

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic int find_job(input int j);
		foreach (ready_order[i])
			if (ready_order[i] == j) return i;
		return -1;
	endfunction

	task automatic apply_request(input logic [CMD_W-1:0] c, input int j, input int p);
		prl_result_t r;
		int pos;
		int k;
		r = '0;
		r.st = ST_OK;
		pos = find_job(j);
		case (c)
			CMD_INSERT: begin
				r.job = ID_W'(j);
				if (pos >= 0) r.st = ST_DUP;
				else begin
					k = 0;
					while (k < ready_order.size() && prio_of[ready_order[k]] <= p) k++;
					ready_order.insert(k, j);
					prio_of[j] = PR_W'(p);
				end
			end
			CMD_REMOVE: begin
				r.job = ID_W'(j);
				if (pos < 0) r.st = ST_NOTQ;
				else ready_order.delete(pos);
			end
			CMD_POP: begin
				if (ready_order.size() > 0) r.job = ID_W'(ready_order.pop_front());
				else r.st = ST_EMPTY;
			end
			default: ;
		endcase
		r.hv = ready_order.size() > 0;
		r.hj = r.hv ? ID_W'(ready_order[0]) : '0;
		expected_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		prl_result_t w;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (!empty && pop) begin
				if (expected_results.size() == 0) begin
					$display("unexpected result at %0t", $realtime);
					errors++;
				end else begin
					w = expected_results.pop_front();
					if (result_job !== w.job) report_mismatch("result_job", result_job, w.job);
					if (status !== w.st) report_mismatch("status", status, w.st);
					if (head_valid !== w.hv) report_mismatch("head_valid", head_valid, w.hv);
					if (head_job !== w.hj) report_mismatch("head_job", head_job, w.hj);
				end
			end
			if (push && !full) apply_request(command, job_id, priority_req);
		end
	end
endmodule
`default_nettype wire

[verif/priority_ready_list_unit_tb.sv]
// ----------------------------------------------------------------------------
// Priority ready list testbench
// Directed and random insert, remove and pop requests with bursty input,
// a stalling result side and one long hold-off; the checker predicts results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module priority_ready_list_unit_tb;
	import prl_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	logic [CMD_W-1:0] command = CMD_NONE;
	logic [ID_W-1:0] job_id = '0;
	logic [PR_W-1:0] priority_req = '0;
	logic empty;
	logic pop = 0;
	logic [ID_W-1:0] result_job;
	logic [ST_W-1:0] status;
	logic head_valid;
	logic [ID_W-1:0] head_job;
	int errors;
	int pending;
	bit sending_done = 0;
	bit hold_off = 0;

	always #2 clk = ~clk;

	priority_ready_list_unit dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .command(command),
		.job_id(job_id), .priority_req(priority_req), .empty(empty), .pop(pop),
		.result_job(result_job), .status(status), .head_valid(head_valid),
		.head_job(head_job)
	);

	priority_ready_list_unit_checker checker_i (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .command(command),
		.job_id(job_id), .priority_req(priority_req), .empty(empty), .pop(pop),
		.result_job(result_job), .status(status), .head_valid(head_valid),
		.head_job(head_job), .errors(errors), .pending(pending)
	);

	// hold the request until accepted
	task automatic send_request(input logic [CMD_W-1:0] c, input int j, input int p);
		push <= 1;
		command <= c;
		job_id <= ID_W'(j);
		priority_req <= PR_W'(p);
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic idle_gap();
		int n;
		n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0;
		if (n > 0) begin
			push <= 0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic random_request();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) send_request(CMD_INSERT, $urandom_range(0, 11), $urandom_range(0, 31));
		else if (r < 70) send_request(CMD_REMOVE, $urandom_range(0, 11), $urandom);
		else if (r < 92) send_request(CMD_POP, $urandom, $urandom);
		else send_request(CMD_W'($urandom), $urandom, $urandom);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		send_request(CMD_POP, 0, 0);
		send_request(CMD_REMOVE, 31, 0);
		send_request(CMD_INSERT, 31, 31);
		send_request(CMD_INSERT, 31, 0);
		send_request(CMD_INSERT, 0, 0);
		send_request(CMD_INSERT, 5, 31);
		send_request(CMD_INSERT, 6, 16);
		send_request(CMD_INSERT, 7, 16);
		send_request(CMD_INSERT, 8, 0);
		send_request(CMD_REMOVE, 6, 0);
		send_request(CMD_REMOVE, 6, 0);
		send_request(CMD_NONE, 21, 10);
		send_request(CMD_POP, 0, 0);
		send_request(CMD_REMOVE, 5, 0);
		send_request(CMD_POP, 0, 0);
		send_request(CMD_POP, 0, 0);
		send_request(CMD_POP, 0, 0);
		send_request(CMD_POP, 0, 0);
		send_request(CMD_POP, 0, 0);
		// fill all slots with random priorities for the longest walks
		for (int i = 0; i < 32; i++) send_request(CMD_INSERT, i, $urandom);
		for (int i = 0; i < 33; i++) send_request(CMD_POP, 0, 0);
		for (int i = 0; i < 400; i++) begin
			if (i == 150) hold_off <= 1;
			random_request();
			idle_gap();
		end
		push <= 0;
		sending_done = 1;
	end

	// result side stall pattern, plus one long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				pop <= 0;
				repeat (600) @(negedge clk);
				hold_off <= 0;
			end
			pop <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
		end
	end

	initial begin
		wait (sending_done);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
